// File: hdl/dara_pkg.sv
// Shared types and constants for the difference array range adder.
// Holds the item and result beats and the controller/datapath command set.
// Depends on nothing.
package dara_pkg;

  localparam int MAX_LENGTH = 64;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int LEN_W      = 7;
  localparam int IDX_W      = 6;
  localparam int DATA_W     = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LENGTH);

  // action codes
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_ADD  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  // read address select
  localparam logic [1:0] RD_FIRST  = 2'd0;
  localparam logic [1:0] RD_LASTP1 = 2'd1;
  localparam logic [1:0] RD_ZERO   = 2'd2;
  localparam logic [1:0] RD_NEXT   = 2'd3;

  // result emit kinds
  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_OK   = 2'd1;
  localparam logic [1:0] EMIT_REJ  = 2'd2;
  localparam logic [1:0] EMIT_ELEM = 2'd3;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        index_first;
    logic [IDX_W-1:0]        index_last;
    logic signed [DATA_W-1:0] amount;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element_value;
    logic [IDX_W-1:0]         element_index;
    logic                     last;
    logic                     status;
  } result_t;

  typedef struct packed {
    logic       capture;
    logic       load_wr;
    logic       add_first;
    logic       add_second;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       scan_init;
    logic       scan_step;
    logic [1:0] emit;
  } dara_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       load_ok;
    logic       range_ok;
    logic       tail_ok;
    logic       scan_end;
  } dara_stat_t;

endpackage

// File: hdl/dara_dp.sv
// Datapath: item register, difference store with valid bits, prefix-sum scan
// and the result register. Driven by dara_ctrl; uses dara_pkg.
module dara_dp import dara_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  item_t            item,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  input  dara_cmd_t        cmd,
  output dara_stat_t       stat,
  output logic             result_strobe,
  output result_t          result
);

  item_t                    item_q;
  logic [LEN_W-1:0]         len_q;
  logic [DATA_W-1:0]        prev;
  logic [DATA_W-1:0]        mem [MAX_LENGTH];
  logic [MAX_LENGTH-1:0]    valid;
  logic [DATA_W-1:0]        rd_data_q;
  logic                     rd_hit_q;
  logic [DATA_W-1:0]        rd_word;
  logic [DATA_W-1:0]        sum;
  logic [DATA_W-1:0]        sum_next;
  logic [ADDR_W-1:0]        ptr;
  logic [LEN_W-1:0]         first_ext;
  logic [LEN_W-1:0]         lastp1;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic [LEN_W-1:0]         len_clamped;

  // clamp the length register into 1..MAX_LENGTH
  always_comb begin
    if (cfg_data == '0) begin
      len_clamped = LEN_W'(1);
    end else if (cfg_data > LEN_W'(MAX_LENGTH)) begin
      len_clamped = LEN_W'(MAX_LENGTH);
    end else begin
      len_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_q <= LEN_RESET;
    end else if (cfg_we) begin
      len_q <= len_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
  end

  assign first_ext = LEN_W'(item_q.index_first);
  assign lastp1    = LEN_W'(item_q.index_last) + LEN_W'(1);

  assign stat.action   = item_q.action;
  assign stat.load_ok  = first_ext < len_q;
  assign stat.range_ok = (item_q.index_first <= item_q.index_last) && (first_ext < len_q);
  assign stat.tail_ok  = lastp1 < len_q;
  assign stat.scan_end = LEN_W'(ptr) == (len_q - LEN_W'(1));

  // an entry never written since reset reads as zero
  assign rd_word = rd_hit_q ? rd_data_q : '0;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_FIRST:  rd_addr = item_q.index_first[ADDR_W-1:0];
      RD_LASTP1: rd_addr = lastp1[ADDR_W-1:0];
      RD_ZERO:   rd_addr = '0;
      RD_NEXT:   rd_addr = ptr + ADDR_W'(1);
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = item_q.index_first[ADDR_W-1:0];
    wr_data = rd_word + item_q.amount;
    priority if (cmd.load_wr) begin
      wr_en   = 1'b1;
      wr_data = (item_q.index_first == '0) ? item_q.amount : item_q.amount - prev;
    end else if (cmd.add_first) begin
      wr_en   = 1'b1;
    end else if (cmd.add_second) begin
      wr_en   = 1'b1;
      wr_addr = lastp1[ADDR_W-1:0];
      wr_data = rd_word - item_q.amount;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_hit_q  <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      prev  <= '0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cmd.load_wr) begin
        prev <= item_q.amount;
      end
    end
  end

  assign sum_next = sum + rd_word;

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      sum <= '0;
      ptr <= '0;
    end else if (cmd.scan_step) begin
      sum <= sum_next;
      ptr <= ptr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (cmd.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      EMIT_ELEM: begin
        result.element_value <= sum_next;
        result.element_index <= IDX_W'(ptr);
        result.last          <= stat.scan_end;
        result.status        <= 1'b0;
      end
      EMIT_REJ: begin
        result.element_value <= '0;
        result.element_index <= '0;
        result.last          <= 1'b1;
        result.status        <= 1'b1;
      end
      EMIT_OK: begin
        result.element_value <= '0;
        result.element_index <= '0;
        result.last          <= 1'b1;
        result.status        <= 1'b0;
      end
      default: begin
        result <= result;
      end
    endcase
  end

endmodule

// File: hdl/dara_ctrl.sv
// Controller state machine: sequences loads, range adds and readout scans.
// Issues commands to dara_dp; uses dara_pkg.
module dara_ctrl import dara_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dara_stat_t stat,
  output logic       busy,
  output dara_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_ADD1     = 3'd2;
  localparam logic [2:0] S_ADD2     = 3'd3;
  localparam logic [2:0] S_READ     = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        unique case (stat.action)
          ACT_LOAD: begin
            cmd.load_wr = stat.load_ok;
            cmd.emit    = stat.load_ok ? EMIT_OK : EMIT_REJ;
          end
          ACT_ADD: begin
            if (stat.range_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_FIRST;
              state_next = S_ADD1;
            end else begin
              cmd.emit = EMIT_REJ;
            end
          end
          ACT_READ: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_ZERO;
            cmd.scan_init = 1'b1;
            state_next    = S_READ;
          end
          default: begin
            cmd.emit = EMIT_REJ;
          end
        endcase
      end
      S_ADD1: begin
        cmd.add_first = 1'b1;
        if (stat.tail_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LASTP1;
          state_next = S_ADD2;
        end else begin
          cmd.emit   = EMIT_OK;
          state_next = S_IDLE;
        end
      end
      S_ADD2: begin
        cmd.add_second = 1'b1;
        cmd.emit       = EMIT_OK;
        state_next     = S_IDLE;
      end
      S_READ: begin
        cmd.emit = EMIT_ELEM;
        if (stat.scan_end) begin
          state_next = S_IDLE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_NEXT;
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/difference_array_range_add.sv
// Difference array range adder: top level joining dara_ctrl and dara_dp.
// Uses dara_pkg for the item and result beat types.
//
// The block keeps a 64-word store of signed 32-bit differences and takes one
// command beat whenever start is high while busy is low. A load beat stores
// its amount minus the previously loaded value; a range-add beat adds the
// amount at the first index and subtracts it just past the last; a readout
// beat streams the prefix sums as the current array, one result beat per
// cycle, with last set on the final element. Every other beat returns one
// result beat with last set and status telling accept (0) or reject (1).
// Result beats appear for exactly one cycle on result_strobe and cannot be
// held off, so the receiver must take them as they come. A new beat is only
// taken once the block is idle again. A load at index 0 stores its amount as
// is. A range add reads then writes each touched entry, the first index and
// then, only when it falls inside the array, the entry just past the last,
// because the store has a single registered read port; a readout makes one
// store read per element. The store is zero after reset through per-entry
// valid bits, so no clearing pass is needed. Write array_length
// (cfg_we/cfg_data) only while the block is idle; 0 acts as 1 and values
// above 64 act as 64.
module difference_array_range_add import dara_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  item_t            item,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  output logic             result_strobe,
  output result_t          result
);

  dara_cmd_t  cmd;
  dara_stat_t stat;

  // sequence each beat through dispatch, store access and result emit
  dara_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // hold the store, the scan sum and the result register
  dara_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .result_strobe (result_strobe),
    .result        (result)
  );

`ifndef SYNTHESIS
  // an accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  // a readout streams without gaps until its last element
  a_scan_gapless: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last) |=> result_strobe)
    else $error("readout stream broke before its last element");

  // the final result of a beat leaves the block ready
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |-> !busy)
    else $error("block still busy on the final result");

  // a rejected beat carries a single closing result with zero payload
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.status) |-> (result.last && result.element_value == '0))
    else $error("malformed reject result");
`endif

endmodule
